@@ hdl/tlpd_pkg.sv @@
// Package with the shared types and constants of the touch long-press detector.
`default_nettype none

package tlpd_pkg;

   // Phase codes of the press state machine.
   localparam logic [2:0] PH_RESET      = 3'd0;
   localparam logic [2:0] PH_RELEASE    = 3'd1;
   localparam logic [2:0] PH_FIRST      = 3'd2;
   localparam logic [2:0] PH_PRESSING   = 3'd3;
   localparam logic [2:0] PH_FIRST_LONG = 3'd4;
   localparam logic [2:0] PH_LONG       = 3'd5;

   // LED colors.
   localparam logic [1:0] COL_OFF   = 2'd0;
   localparam logic [1:0] COL_WHITE = 2'd1;
   localparam logic [1:0] COL_RED   = 2'd2;
   localparam logic [1:0] COL_GREEN = 2'd3;

   // Audio commands.
   localparam logic [2:0] AUD_NONE    = 3'd0;
   localparam logic [2:0] AUD_STOP    = 3'd1;
   localparam logic [2:0] AUD_RUNNING = 3'd2;
   localparam logic [2:0] AUD_CORRECT = 3'd3;
   localparam logic [2:0] AUD_WRONG   = 3'd4;

   // Request kinds.
   localparam logic REQ_POLL = 1'b0;
   localparam logic REQ_LOAD = 1'b1;

   // Configuration register indexes.
   localparam logic CSR_GLITCH = 1'b0;
   localparam logic CSR_HOLD   = 1'b1;

   localparam logic [15:0] GLITCH_RESET = 16'd500;
   localparam logic [15:0] HOLD_RESET   = 16'd4000;

   // Blink ramp: delay = BLINK_MAX - ceil(e*e / BLINK_DIV), e clamped to BLINK_RAMP.
   localparam logic [31:0] BLINK_RAMP = 32'd3000;
   localparam logic [31:0] BLINK_MAX  = 32'd200;
   localparam logic [23:0] BLINK_DIV  = 24'd60000;

   typedef struct packed {
      logic       req_type;
      logic       touch_level;
      logic [31:0] now_ms;
      logic       must_value;
   } req_word_type;

   typedef struct packed {
      logic       hold_confirmed;
      logic       led_update;
      logic [1:0] led_color;
      logic [2:0] audio_cmd;
   } rsp_word_type;

   typedef struct packed {
      logic [2:0]  phase;
      logic [31:0] press_start_ms;
      logic [31:0] last_touch_ms;
      logic [31:0] blink_mark_ms;
      logic        blink_on;
      logic        must_press;
   } state_type;

endpackage

`default_nettype wire

@@ hdl/tlpd_req_if.sv @@
// Request channel interface of the touch long-press detector.
`default_nettype none

interface tlpd_req_if;
   logic        valid;
   logic        ready;
   logic        req_type;
   logic        touch_level;
   logic [31:0] now_ms;
   logic        must_value;

   modport source (output valid, output req_type, output touch_level, output now_ms,
                   output must_value, input ready);
   modport sink (input valid, input req_type, input touch_level, input now_ms,
                 input must_value, output ready);
endinterface

`default_nettype wire

@@ hdl/tlpd_rsp_if.sv @@
// Response channel interface of the touch long-press detector.
`default_nettype none

interface tlpd_rsp_if;
   logic       valid;
   logic       ready;
   logic       hold_confirmed;
   logic       led_update;
   logic [1:0] led_color;
   logic [2:0] audio_cmd;

   modport source (output valid, output hold_confirmed, output led_update, output led_color,
                   output audio_cmd, input ready);
   modport sink (input valid, input hold_confirmed, input led_update, input led_color,
                 input audio_cmd, output ready);
endinterface

`default_nettype wire

@@ hdl/tlpd_step.sv @@
// Next-state and response logic of the touch long-press detector for one word.
`default_nettype none

module tlpd_step
   import tlpd_pkg::*;
(
   input  wire state_type    state,
   input  wire req_word_type req,
   input  wire logic [15:0]  glitch_limit,
   input  wire logic [15:0]  hold_limit,
   output state_type         state_next,
   output rsp_word_type      rsp
);

   logic        touch;
   logic [31:0] last_eff;
   logic [31:0] gap;
   logic [31:0] held;
   logic [31:0] since_blink;
   logic        gap_over;
   logic        hold_over;
   logic [11:0] ramp;
   logic [23:0] ramp_sq;
   logic [7:0]  slack;
   logic [23:0] slack_scaled;
   logic        blink_due;

   assign touch    = (req.req_type == REQ_POLL) && req.touch_level;
   assign last_eff = touch ? req.now_ms : state.last_touch_ms;

   assign gap       = req.now_ms - last_eff;
   assign held      = req.now_ms - state.press_start_ms;
   assign gap_over  = gap > {16'd0, glitch_limit};
   assign hold_over = held > {16'd0, hold_limit};

   // The LED toggles when since_blink > BLINK_MAX - ceil(sq / BLINK_DIV). Below the
   // maximum this is the same as sq > BLINK_DIV * (BLINK_MAX - since_blink), so no
   // division is needed.
   assign ramp         = (held > BLINK_RAMP) ? BLINK_RAMP[11:0] : held[11:0];
   assign ramp_sq      = {12'd0, ramp} * {12'd0, ramp};
   assign since_blink  = req.now_ms - state.blink_mark_ms;
   assign slack        = BLINK_MAX[7:0] - since_blink[7:0];
   assign slack_scaled = {16'd0, slack} * BLINK_DIV;
   assign blink_due    = (since_blink > BLINK_MAX) || (ramp_sq > slack_scaled);

   always_comb begin
      state_next = state;
      rsp        = '0;
      if (req.req_type == REQ_LOAD) begin
         state_next.must_press = req.must_value;
      end else begin
         state_next.last_touch_ms = last_eff;
         unique case (state.phase)
            PH_RELEASE: begin
               if (touch) begin
                  state_next.phase = PH_FIRST;
               end
               rsp.led_update = 1'b1;
               rsp.led_color  = state.must_press ? COL_WHITE : COL_OFF;
            end
            PH_FIRST: begin
               state_next.phase          = PH_PRESSING;
               state_next.press_start_ms = req.now_ms;
               rsp.led_update = 1'b1;
               rsp.led_color  = state.must_press ? COL_GREEN : COL_RED;
               rsp.audio_cmd  = AUD_RUNNING;
            end
            PH_PRESSING: begin
               // A confirmed hold takes priority over a gap in the same poll.
               if (hold_over) begin
                  state_next.phase = PH_FIRST_LONG;
               end else if (gap_over) begin
                  state_next.phase = PH_RESET;
               end
               if (blink_due) begin
                  state_next.blink_mark_ms = req.now_ms;
                  state_next.blink_on      = !state.blink_on;
                  rsp.led_update = 1'b1;
                  if (state.must_press) begin
                     rsp.led_color = !state.blink_on ? COL_WHITE : COL_GREEN;
                  end else begin
                     rsp.led_color = !state.blink_on ? COL_OFF : COL_RED;
                  end
               end
            end
            PH_FIRST_LONG: begin
               state_next.phase = PH_LONG;
               rsp.led_update = 1'b1;
               rsp.led_color  = state.must_press ? COL_GREEN : COL_RED;
               rsp.audio_cmd  = state.must_press ? AUD_CORRECT : AUD_WRONG;
            end
            PH_LONG: begin
               if (gap_over) begin
                  state_next.phase = PH_RESET;
               end
               state_next.must_press = 1'b0;
               rsp.hold_confirmed    = 1'b1;
            end
            default: begin
               // The reset phase and unused codes stop the audio and go to release.
               state_next.phase = PH_RELEASE;
               rsp.audio_cmd    = AUD_STOP;
            end
         endcase
      end
   end

endmodule

`default_nettype wire

@@ hdl/touch_long_press_detector.sv @@
// Top level of the touch long-press detector.
//
//   Channel   Dir   Word contents
//   req_ch    in    req_type, touch_level, now_ms, must_value
//   rsp_ch    out   hold_confirmed, led_update, led_color, audio_cmd
//   csr_*     in    write enable, register index, 16-bit write data
//
// Every request word gives exactly one response word. A word is taken into an input
// register, goes through the next-state logic into the response register and leaves
// from there; one word is accepted every cycle while rsp_ch does not stall.
// A stall on rsp_ch holds the response register and then the input register; req_ch
// keeps accepting as long as either register can move.
// Reset is synchronous and active high; it restores the register defaults (500 ms gap
// limit, 4000 ms hold limit), the release phase and clears all timestamps and flags.
`default_nettype none

module touch_long_press_detector
   import tlpd_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   tlpd_req_if.sink         req_ch,
   tlpd_rsp_if.source       rsp_ch,
   input  wire logic        csr_write_en,
   input  wire logic        csr_index,
   input  wire logic [15:0] csr_write_data
);

   logic         in_valid_ff;
   req_word_type in_word_ff;
   logic         out_valid_ff;
   rsp_word_type out_word_ff;
   state_type    state_ff;
   logic [15:0]  glitch_limit_ff;
   logic [15:0]  hold_limit_ff;

   state_type    state_in;
   rsp_word_type rsp_in;
   logic         advance;
   logic         accept;

   // The input word moves on when the response register is empty or being drained.
   assign advance = in_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign accept  = req_ch.valid && req_ch.ready;

   assign req_ch.ready = !in_valid_ff || advance;

   tlpd_step u_step (
      .state        (state_ff),
      .req          (in_word_ff),
      .glitch_limit (glitch_limit_ff),
      .hold_limit   (hold_limit_ff),
      .state_next   (state_in),
      .rsp          (rsp_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_word_ff.req_type    <= req_ch.req_type;
         in_word_ff.touch_level <= req_ch.touch_level;
         in_word_ff.now_ms      <= req_ch.now_ms;
         in_word_ff.must_value  <= req_ch.must_value;
      end
      if (advance) begin
         out_word_ff <= rsp_in;
      end
   end

   // Detector state advances once per word.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.phase          <= PH_RELEASE;
         state_ff.press_start_ms <= '0;
         state_ff.last_touch_ms  <= '0;
         state_ff.blink_mark_ms  <= '0;
         state_ff.blink_on       <= 1'b0;
         state_ff.must_press     <= 1'b0;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         glitch_limit_ff <= GLITCH_RESET;
         hold_limit_ff   <= HOLD_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_GLITCH: glitch_limit_ff <= csr_write_data;
            CSR_HOLD:   hold_limit_ff   <= csr_write_data;
            default:    ;
         endcase
      end
   end

   assign rsp_ch.valid          = out_valid_ff;
   assign rsp_ch.hold_confirmed = out_word_ff.hold_confirmed;
   assign rsp_ch.led_update     = out_word_ff.led_update;
   assign rsp_ch.led_color      = out_word_ff.led_color;
   assign rsp_ch.audio_cmd      = out_word_ff.audio_cmd;

endmodule

`default_nettype wire

@@ verif/tlpd_checker.sv @@
// Checker that tracks the press state machine and compares every response word.
`timescale 1ns / 100ps

module tlpd_checker
   import tlpd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   tlpd_req_if         req_ch,
   tlpd_rsp_if         rsp_ch,
   input  logic        csr_write_en,
   input  logic        csr_index,
   input  logic [15:0] csr_write_data,
   output int          fail_count,
   output int          pending_words,
   output int          checked_words,
   output int          long_press_polls,
   output int          gap_hold_polls
);

   localparam int REPORT_LIMIT = 10;

   // Shadow of the limits and of the press tracking state.
   logic [15:0] glitch_ms;
   logic [15:0] hold_ms;
   logic [2:0]  phase;
   logic [31:0] press_start_ms;
   logic [31:0] last_touch_ms;
   logic [31:0] blink_mark_ms;
   logic        blink_on;
   logic        must_press;

   rsp_word_type indication_q[$];

   // Blink period shrinks with the square of the hold time, rounded up.
   function automatic logic [31:0] blink_period_ms(logic [31:0] t);
      logic [31:0] held;
      held = t - press_start_ms;
      if (held > BLINK_RAMP) held = BLINK_RAMP;
      return BLINK_MAX - (held * held + {8'd0, BLINK_DIV} - 32'd1) / {8'd0, BLINK_DIV};
   endfunction

   function automatic rsp_word_type track_press(req_word_type w);
      rsp_word_type r;
      logic [31:0]  t;
      logic         gap_hit;
      logic         hold_hit;
      r = '0;
      t = w.now_ms;
      if (w.req_type == REQ_LOAD) begin
         must_press = w.must_value;
      end else begin
         if (w.touch_level) last_touch_ms = t;
         case (phase)
            PH_RELEASE: begin
               if (w.touch_level) phase = PH_FIRST;
               r.led_update = 1'b1;
               r.led_color  = must_press ? COL_WHITE : COL_OFF;
            end
            PH_FIRST: begin
               phase          = PH_PRESSING;
               press_start_ms = t;
               r.led_update   = 1'b1;
               r.led_color    = must_press ? COL_GREEN : COL_RED;
               r.audio_cmd    = AUD_RUNNING;
            end
            PH_PRESSING: begin
               gap_hit  = (t - last_touch_ms) > {16'd0, glitch_ms};
               hold_hit = (t - press_start_ms) > {16'd0, hold_ms};
               if (gap_hit) phase = PH_RESET;
               // A confirmed hold takes precedence over an abandoned press.
               if (hold_hit) phase = PH_FIRST_LONG;
               if (gap_hit && hold_hit) gap_hold_polls++;
               if ((t - blink_mark_ms) > blink_period_ms(t)) begin
                  blink_mark_ms = t;
                  blink_on      = !blink_on;
                  r.led_update  = 1'b1;
                  if (must_press) r.led_color = blink_on ? COL_WHITE : COL_GREEN;
                  else r.led_color = blink_on ? COL_OFF : COL_RED;
               end
            end
            PH_FIRST_LONG: begin
               r.led_update = 1'b1;
               r.led_color  = must_press ? COL_GREEN : COL_RED;
               r.audio_cmd  = must_press ? AUD_CORRECT : AUD_WRONG;
               phase        = PH_LONG;
            end
            PH_LONG: begin
               if ((t - last_touch_ms) > {16'd0, glitch_ms}) phase = PH_RESET;
               must_press       = 1'b0;
               r.hold_confirmed = 1'b1;
               long_press_polls++;
            end
            default: begin
               r.audio_cmd = AUD_STOP;
               phase       = PH_RELEASE;
            end
         endcase
      end
      return r;
   endfunction

   task automatic note_failure(input string msg);
      fail_count++;
      if (fail_count <= REPORT_LIMIT) $display("%t: %s", $realtime, msg);
   endtask

   always @(posedge clock) begin : watch
      rsp_word_type want;
      rsp_word_type seen;
      if (reset) begin
         glitch_ms        = GLITCH_RESET;
         hold_ms          = HOLD_RESET;
         phase            = PH_RELEASE;
         press_start_ms   = '0;
         last_touch_ms    = '0;
         blink_mark_ms    = '0;
         blink_on         = 1'b0;
         must_press       = 1'b0;
         fail_count       = 0;
         checked_words    = 0;
         long_press_polls = 0;
         gap_hold_polls   = 0;
         indication_q.delete();
      end else begin
         if (csr_write_en) begin
            if (csr_index == CSR_GLITCH) glitch_ms = csr_write_data;
            else hold_ms = csr_write_data;
         end
         if (req_ch.valid && req_ch.ready) begin
            indication_q.push_back(track_press({req_ch.req_type, req_ch.touch_level,
                                                req_ch.now_ms, req_ch.must_value}));
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            seen = {rsp_ch.hold_confirmed, rsp_ch.led_update, rsp_ch.led_color,
                    rsp_ch.audio_cmd};
            if (indication_q.size() == 0) begin
               note_failure($sformatf("response word %h with nothing outstanding", seen));
            end else begin
               want = indication_q.pop_front();
               checked_words++;
               if (seen.hold_confirmed !== want.hold_confirmed ||
                   seen.led_update !== want.led_update ||
                   seen.led_color !== want.led_color ||
                   seen.audio_cmd !== want.audio_cmd) begin
                  note_failure($sformatf(
                     {"word %0d: expected hc=%b upd=%b col=%0d aud=%0d, ",
                      "got hc=%b upd=%b col=%0d aud=%0d"},
                     checked_words, want.hold_confirmed, want.led_update, want.led_color,
                     want.audio_cmd, seen.hold_confirmed, seen.led_update, seen.led_color,
                     seen.audio_cmd));
               end
            end
         end
      end
      pending_words = indication_q.size();
   end

endmodule

@@ verif/tb_touch_long_press_detector.sv @@
// Testbench top for the touch long-press detector: stimulus, idling and verdict.
`timescale 1ns / 100ps

module tb_touch_long_press_detector;
   import tlpd_pkg::*;

   // The watchdog ends the run when no word moves on either channel for this long.
   localparam int WATCHDOG_LIMIT  = 2000;
   // Length of the deliberate response stall that backs up the pipeline.
   localparam int HOLD_OFF_CYCLES = 80;
   // Items per random phase.
   localparam int PHASE_ITEMS     = 85;

   logic        clock = 1'b0;
   logic        reset;
   logic        csr_write_en;
   logic        csr_index;
   logic [15:0] csr_write_data;

   int fail_count;
   int pending_words;
   int checked_words;
   int long_press_polls;
   int gap_hold_polls;
   int sent_words;
   int stuck_cycles;

   // Millisecond time seen by the sensor; wraps at 2^32 like the real counter.
   logic [31:0] wall_ms;

   // Idling controls for the request and response sides.
   bit req_idle_on;
   bit rsp_idle_on;
   bit hold_off_pending;

   tlpd_req_if req_if ();
   tlpd_rsp_if rsp_if ();

   touch_long_press_detector DUT (
      .clock          (clock),
      .reset          (reset),
      .req_ch         (req_if),
      .rsp_ch         (rsp_if),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data)
   );

   tlpd_checker press_checker (
      .clock            (clock),
      .reset            (reset),
      .req_ch           (req_if),
      .rsp_ch           (rsp_if),
      .csr_write_en     (csr_write_en),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .fail_count       (fail_count),
      .pending_words    (pending_words),
      .checked_words    (checked_words),
      .long_press_polls (long_press_polls),
      .gap_hold_polls   (gap_hold_polls)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Offer one word, starting at a falling edge, and return at the falling edge after
   // it was taken. The valid is only dropped when an idle gap is inserted, so a
   // back-to-back word keeps valid high without a glitch.
   task automatic put_word(input req_word_type w);
      if (req_idle_on && $urandom_range(0, 99) < 30) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(negedge clock);
      end
      req_if.valid       <= 1'b1;
      req_if.req_type    <= w.req_type;
      req_if.touch_level <= w.touch_level;
      req_if.now_ms      <= w.now_ms;
      req_if.must_value  <= w.must_value;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      sent_words++;
      @(negedge clock);
   endtask

   // A sensor poll; the must-press field is random since a poll ignores it.
   task automatic poll(input logic touch, input logic [31:0] t);
      req_word_type w;
      w.req_type    = REQ_POLL;
      w.touch_level = touch;
      w.now_ms      = t;
      w.must_value  = 1'($urandom_range(0, 1));
      put_word(w);
   endtask

   // A must-press load; the poll fields carry noise.
   task automatic load_flag(input logic must);
      req_word_type w;
      w.req_type    = REQ_LOAD;
      w.touch_level = 1'($urandom_range(0, 1));
      w.now_ms      = $urandom;
      w.must_value  = must;
      put_word(w);
   endtask

   // Both limits in consecutive cycles; the enable stays high across the pair.
   task automatic write_limits(input logic [15:0] glitch, input logic [15:0] hold);
      csr_write_en   <= 1'b1;
      csr_index      <= CSR_GLITCH;
      csr_write_data <= glitch;
      @(negedge clock);
      csr_index      <= CSR_HOLD;
      csr_write_data <= hold;
      @(negedge clock);
      csr_write_en   <= 1'b0;
   endtask

   // Stop offering, wait for every outstanding response, then let the two-stage
   // pipeline empty before the limits may change.
   task automatic drain();
      req_if.valid <= 1'b0;
      while (pending_words != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // One press: a little release, a hold with random touch gaps that may or may not
   // reach the hold limit, a few polls to walk through the long-press phases, and a
   // gap long enough to end the press.
   task automatic press_sequence(input logic [15:0] glitch, input logic [15:0] hold);
      int unsigned span;
      int unsigned step_cap;
      int unsigned pick;
      int          n;
      logic [31:0] start_ms;
      repeat ($urandom_range(1, 2)) begin
         wall_ms += $urandom_range(1, 50);
         poll(1'b0, wall_ms);
      end
      step_cap = hold / 6 + 2;
      if ($urandom_range(0, 3) == 0) span = $urandom_range(0, hold);
      else span = hold + $urandom_range(1, hold / 4 + 50);
      start_ms = wall_ms;
      n = 0;
      while ((wall_ms - start_ms) <= span && n < 30) begin
         pick = $urandom_range(0, 99);
         if (pick < 6) begin
            // Gap right at the glitch limit or one past it.
            wall_ms += glitch + $urandom_range(0, 1);
            poll(1'b0, wall_ms);
         end else if (pick < 18) begin
            wall_ms += $urandom_range(1, step_cap);
            poll(1'b0, wall_ms);
         end else begin
            // Short steps leave the blink timer running, long ones make it fire.
            if ($urandom_range(0, 1)) wall_ms += $urandom_range(1, 60);
            else wall_ms += $urandom_range(1, step_cap);
            poll(1'b1, wall_ms);
         end
         n++;
      end
      repeat ($urandom_range(1, 3)) begin
         wall_ms += $urandom_range(1, 40);
         poll(1'b1, wall_ms);
      end
      wall_ms += glitch + 1 + $urandom_range(0, 200);
      poll(1'b0, wall_ms);
      wall_ms += $urandom_range(1, 20);
      poll(1'b0, wall_ms);
   endtask

   // Random traffic under one pair of limits. With squeeze set, part of the phase
   // runs without idling and the response side stalls long enough to fill the block.
   task automatic random_phase(input logic [15:0] glitch, input logic [15:0] hold,
                               input bit squeeze);
      int          first;
      int unsigned pick;
      bit          squeezed;
      write_limits(glitch, hold);
      first    = sent_words;
      squeezed = 1'b0;
      if ($urandom_range(0, 1)) wall_ms = $urandom;
      else wall_ms = 32'hFFFF_F000 + $urandom_range(0, 4000);
      while (sent_words - first < PHASE_ITEMS) begin
         if (squeeze && !squeezed && sent_words - first >= 30) begin
            squeezed         = 1'b1;
            req_idle_on      = 1'b0;
            rsp_idle_on      = 1'b0;
            hold_off_pending = 1'b1;
         end
         if (squeezed && sent_words - first >= 70) begin
            req_idle_on = 1'b1;
            rsp_idle_on = 1'b1;
         end
         pick = $urandom_range(0, 99);
         if (pick < 70) begin
            press_sequence(glitch, hold);
         end else if (pick < 82) begin
            load_flag(1'($urandom_range(0, 1)));
         end else if (pick < 91) begin
            wall_ms += $urandom_range(0, 2 * glitch + 2);
            poll(1'($urandom_range(0, 1)), wall_ms);
         end else begin
            // A poll at an arbitrary time, unrelated to the running clock.
            poll(1'($urandom_range(0, 1)), $urandom);
         end
      end
      drain();
   endtask

   // Response side: random back-pressure, a no-stall mode, and a long hold-off whose
   // length is counted here.
   initial begin
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_pending) begin
            hold_off_pending = 1'b0;
            rsp_if.ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(negedge clock);
         end
         rsp_if.ready <= rsp_idle_on ? ($urandom_range(0, 99) >= 30) : 1'b1;
      end
   end

   // Watchdog on cycles in which no word moves on either channel.
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         stuck_cycles = 0;
      end else begin
         stuck_cycles++;
         if (stuck_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog expired after %0d cycles with no word moving.", stuck_cycles);
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   initial begin : stimulus
      logic [31:0] base;
      reset              = 1'b1;
      req_if.valid       = 1'b0;
      req_if.req_type    = REQ_POLL;
      req_if.touch_level = 1'b0;
      req_if.now_ms      = '0;
      req_if.must_value  = 1'b0;
      csr_write_en       = 1'b0;
      csr_index          = CSR_GLITCH;
      csr_write_data     = '0;
      req_idle_on        = 1'b1;
      rsp_idle_on        = 1'b1;
      hold_off_pending   = 1'b0;
      sent_words         = 0;
      wall_ms            = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed part under the power-on limits, with the press starting just
      // before the millisecond counter wraps.
      write_limits(GLITCH_RESET, HOLD_RESET);
      base = 32'hFFFF_FF00;
      load_flag(1'b1);
      poll(1'b0, 32'h0000_0000);
      poll(1'b1, base);
      poll(1'b1, base + 10);
      poll(1'b1, base + 20);
      // The touch drops out past the glitch limit, so the press is abandoned and
      // the following poll stops the audio.
      poll(1'b0, base + 600);
      poll(1'b0, base + 610);
      load_flag(1'b0);
      poll(1'b1, base + 700);
      poll(1'b1, base + 710);
      // Gap and hold exceed their limits in the same poll; the hold wins.
      poll(1'b0, base + 5000);
      poll(1'b1, base + 5010);
      poll(1'b1, base + 5020);
      poll(1'b0, base + 5600);
      poll(1'b0, base + 5610);
      load_flag(1'b1);
      poll(1'b1, base + 6000);
      poll(1'b1, base + 6001);
      // Held exactly to the limit, then one millisecond past it.
      poll(1'b1, base + 10001);
      poll(1'b1, base + 10002);
      poll(1'b1, base + 10010);
      poll(1'b1, base + 10020);
      poll(1'b0, base + 11000);
      poll(1'b0, 32'hFFFF_FFFF);
      drain();

      // Random part over several limit settings, the extremes among them.
      random_phase(16'd0, 16'd0, 1'b0);
      random_phase(16'hFFFF, 16'hFFFF, 1'b0);
      random_phase(16'd300, 16'd1500, 1'b1);
      random_phase(16'($urandom_range(1, 800)), 16'($urandom_range(1, 6000)), 1'b0);

      $display("Sent %0d request words and checked %0d responses under five limit settings.",
               sent_words, checked_words);
      $display("Saw %0d long-press polls and %0d polls where gap and hold expired together.",
               long_press_polls, gap_hold_polls);
      if (fail_count == 0 && pending_words == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

@@ sim.f @@
hdl/tlpd_pkg.sv
hdl/tlpd_req_if.sv
hdl/tlpd_rsp_if.sv
hdl/tlpd_step.sv
hdl/touch_long_press_detector.sv
verif/tlpd_checker.sv
verif/tb_touch_long_press_detector.sv
